// ----- rtl/mtsw_pkg.sv -----
// shared types, operation codes and constants of the motion to scroll wheel block
`timescale 1ns / 1ps
`default_nettype none
package mtsw_pkg;

    typedef struct packed {
        logic signed [15:0] x_motion;
        logic signed [15:0] y_motion;
        logic               x_absolute;
        logic               y_absolute;
        logic [31:0]        event_time;
    } t_in_item;

    typedef struct packed {
        logic [2:0] horizontal_button;
        logic [9:0] horizontal_clicks;
        logic [2:0] vertical_button;
        logic [9:0] vertical_clicks;
    } t_out_item;

    localparam logic [3:0] OP_NONE      = 4'd0;
    localparam logic [3:0] OP_LOAD      = 4'd1;
    localparam logic [3:0] OP_VEL_INIT  = 4'd2;
    localparam logic [3:0] OP_DIV_STEP  = 4'd3;
    localparam logic [3:0] OP_CBRT_INIT = 4'd4;
    localparam logic [3:0] OP_CBRT_STEP = 4'd5;
    localparam logic [3:0] OP_MUL_M     = 4'd6;
    localparam logic [3:0] OP_MUL_P     = 4'd7;
    localparam logic [3:0] OP_P_SUM     = 4'd8;
    localparam logic [3:0] OP_MUL_G     = 4'd9;
    localparam logic [3:0] OP_W_SUM     = 4'd10;
    localparam logic [3:0] OP_ACC       = 4'd11;
    localparam logic [3:0] OP_CLICKS    = 4'd12;
    localparam logic [3:0] OP_ZERO      = 4'd13;
    localparam logic [3:0] OP_DIV5      = 4'd14;

    typedef struct packed {
        logic [3:0] op;
        logic       axis;
    } t_cmd;

    typedef struct packed {
        logic skip;
    } t_status;

    localparam logic CFG_INVERT = 1'b0;
    localparam logic CFG_GAIN   = 1'b1;

    localparam logic [15:0] GAIN_RESET = 16'd4096;

    localparam int DIV_STEPS  = 32;
    localparam int CBRT_STEPS = 21;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    localparam logic [2:0] BTN_NONE  = 3'd0;
    localparam logic [2:0] BTN_UP    = 3'd4;
    localparam logic [2:0] BTN_DOWN  = 3'd5;
    localparam logic [2:0] BTN_LEFT  = 3'd6;
    localparam logic [2:0] BTN_RIGHT = 3'd7;

endpackage
`default_nettype wire

// ----- rtl/mtsw_datapath.sv -----
// datapath: state, velocity divider, cube root, multipliers and offset accumulators
`timescale 1ns / 1ps
`default_nettype none
module mtsw_datapath (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire mtsw_pkg::t_cmd      i_cmd,
    input  wire mtsw_pkg::t_in_item  i_in_item,
    input  wire logic                i_cfg_we,
    input  wire logic                i_cfg_index,
    input  wire logic [15:0]         i_cfg_data,
    output mtsw_pkg::t_status        o_status,
    output mtsw_pkg::t_out_item      o_out_item
);

    typedef struct packed {
        logic               fire;
        logic               pos;
        logic [9:0]         n;
        logic signed [27:0] acc;
    } t_click;

    localparam logic [46:0]        P_CAP     = 47'h4000_0000_0000;
    localparam logic [29:0]        W_CAP     = 30'd671088640;
    localparam logic signed [29:0] ACC_LIMIT = 30'sd67043328;
    localparam logic [27:0]        ONE_Q16   = 28'd65536;
    localparam logic [31:0]        DIV5_MUL  = 32'hCCCC_CCCD;

    logic               r_invert;
    logic [15:0]        r_gain;
    logic               r_have_x, r_have_y;
    logic signed [15:0] r_prev_x, r_prev_y;
    logic [31:0]        r_prev_time;
    logic signed [27:0] r_acc_x, r_acc_y;

    logic signed [16:0] r_dx, r_dy;
    logic [31:0]        r_dt;
    logic               r_skip;
    logic [31:0]        r_rem, r_quo, r_den;
    logic [30:0]        r_vel;
    logic [62:0]        r_cx;
    logic [47:0]        r_crem;
    logic [20:0]        r_cy;
    logic [41:0]        r_cysq;
    logic [35:0]        r_m;
    logic [63:0]        r_pl;
    logic [35:0]        r_ph;
    logic [46:0]        r_p;
    logic [47:0]        r_gl;
    logic [30:0]        r_gh;
    mtsw_pkg::t_out_item r_out;

    function automatic t_click extract(input logic signed [27:0] acc);
        t_click      c;
        logic [27:0] mag;
        mag    = acc[27] ? 28'(-acc) : 28'(acc);
        c.fire = mag > ONE_Q16;
        c.pos  = !acc[27];
        c.n    = c.fire ? mag[25:16] : 10'd0;
        c.acc  = c.pos ? acc - $signed({2'b00, c.n, 16'd0})
                       : acc + $signed({2'b00, c.n, 16'd0});
        return c;
    endfunction

    logic signed [16:0] d_sel, d_neg, x_delta, y_delta;
    logic [15:0]        ad;
    logic [32:0]        trial, rem_sh33;
    logic [30:0]        vel_sat;
    logic [47:0]        crem_sh, cb;
    logic [21:0]        cy2;
    logic [43:0]        cysq4, ct;
    logic [51:0]        prod_m;
    logic [67:0]        psum;
    logic [62:0]        pg, w;
    logic [29:0]        wc;
    logic [63:0]        div5;
    logic [27:0]        mag;
    logic               neg;
    logic signed [27:0] acc_cur;
    logic signed [29:0] acc_sum;
    t_click             cx, cy;

    always_comb begin
        d_sel    = i_cmd.axis ? r_dy : r_dx;
        d_neg    = -d_sel;
        ad       = d_sel[16] ? d_neg[15:0] : d_sel[15:0];
        x_delta  = 17'(i_in_item.x_motion) - 17'(r_prev_x);
        y_delta  = 17'(i_in_item.y_motion) - 17'(r_prev_y);
        rem_sh33 = {r_rem, r_quo[31]};
        trial    = rem_sh33 - {1'b0, r_den};
        vel_sat  = r_quo[31] ? 31'h7FFF_FFFF : r_quo[30:0];
        crem_sh  = {r_crem[44:0], r_cx[62:60]};
        cy2      = {r_cy, 1'b0};
        cysq4    = {r_cysq, 2'b00};
        ct       = cysq4 + {22'd0, cy2};
        cb       = {3'b000, ct, 1'b0} + {4'd0, ct} + 48'd1;
        prod_m   = 52'(r_vel) * 52'(r_cy);
        psum     = {4'd0, r_pl} + {r_ph, 32'd0};
        pg       = {15'd0, r_gl} + {r_gh, 32'd0};
        w        = i_cmd.axis ? (pg >> 13) : (pg >> 14);
        wc       = (w >= 63'(W_CAP)) ? W_CAP : w[29:0];
        div5     = {32'd0, r_quo} * {32'd0, DIV5_MUL};
        mag      = r_quo[27:0];
        neg      = d_sel[16] ^ !r_invert;
        acc_cur  = i_cmd.axis ? r_acc_y : r_acc_x;
        acc_sum  = 30'(acc_cur) + (neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag}));
        cx       = extract(r_acc_x);
        cy       = extract(r_acc_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invert    <= 1'b0;
            r_gain      <= mtsw_pkg::GAIN_RESET;
            r_have_x    <= 1'b0;
            r_have_y    <= 1'b0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_prev_time <= '0;
            r_acc_x     <= '0;
            r_acc_y     <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == mtsw_pkg::CFG_INVERT) begin
                    r_invert <= i_cfg_data[0];
                end else begin
                    r_gain <= i_cfg_data;
                end
            end
            case (i_cmd.op)
                mtsw_pkg::OP_LOAD: begin
                    if (i_in_item.x_absolute) begin
                        r_prev_x <= i_in_item.x_motion;
                        r_have_x <= 1'b1;
                    end
                    if (i_in_item.y_absolute) begin
                        r_prev_y <= i_in_item.y_motion;
                        r_have_y <= 1'b1;
                    end
                    if (r_prev_time == 32'd0 || i_in_item.event_time != r_prev_time) begin
                        r_prev_time <= i_in_item.event_time;
                    end
                end
                mtsw_pkg::OP_ACC: begin
                    if (acc_sum > ACC_LIMIT) begin
                        if (i_cmd.axis) r_acc_y <= 28'(ACC_LIMIT);
                        else r_acc_x <= 28'(ACC_LIMIT);
                    end else if (acc_sum < -ACC_LIMIT) begin
                        if (i_cmd.axis) r_acc_y <= 28'(-ACC_LIMIT);
                        else r_acc_x <= 28'(-ACC_LIMIT);
                    end else begin
                        if (i_cmd.axis) r_acc_y <= acc_sum[27:0];
                        else r_acc_x <= acc_sum[27:0];
                    end
                end
                mtsw_pkg::OP_CLICKS: begin
                    r_acc_x <= cx.acc;
                    r_acc_y <= cy.acc;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            mtsw_pkg::OP_LOAD: begin
                r_dx   <= i_in_item.x_absolute ? (r_have_x ? x_delta : 17'sd0)
                                               : 17'(i_in_item.x_motion);
                r_dy   <= i_in_item.y_absolute ? (r_have_y ? y_delta : 17'sd0)
                                               : 17'(i_in_item.y_motion);
                r_dt   <= i_in_item.event_time - r_prev_time;
                r_skip <= (r_prev_time == 32'd0) || (i_in_item.event_time == r_prev_time);
            end
            mtsw_pkg::OP_VEL_INIT: begin
                r_quo <= {ad, 16'd0};
                r_rem <= '0;
                r_den <= r_dt;
            end
            mtsw_pkg::OP_DIV_STEP: begin
                if (!trial[32]) begin
                    r_rem <= trial[31:0];
                    r_quo <= {r_quo[30:0], 1'b1};
                end else begin
                    r_rem <= rem_sh33[31:0];
                    r_quo <= {r_quo[30:0], 1'b0};
                end
            end
            mtsw_pkg::OP_CBRT_INIT: begin
                r_vel  <= vel_sat;
                r_cx   <= {vel_sat, 32'd0};
                r_crem <= '0;
                r_cy   <= '0;
                r_cysq <= '0;
            end
            mtsw_pkg::OP_CBRT_STEP: begin
                r_cx <= {r_cx[59:0], 3'b000};
                if (crem_sh >= cb) begin
                    r_crem <= crem_sh - cb;
                    r_cy   <= {r_cy[19:0], 1'b1};
                    r_cysq <= 42'(cysq4 + {21'd0, cy2, 1'b0} + 44'd1);
                end else begin
                    r_crem <= crem_sh;
                    r_cy   <= {r_cy[19:0], 1'b0};
                    r_cysq <= cysq4[41:0];
                end
            end
            mtsw_pkg::OP_MUL_M: begin
                r_m <= prod_m[51:16];
            end
            mtsw_pkg::OP_MUL_P: begin
                r_pl <= 64'(r_m[31:0]) * 64'(r_dt);
                r_ph <= 36'(r_m[35:32]) * 36'(r_dt);
            end
            mtsw_pkg::OP_P_SUM: begin
                r_p <= (psum > 68'(P_CAP)) ? P_CAP : psum[46:0];
            end
            mtsw_pkg::OP_MUL_G: begin
                r_gl <= 48'(r_p[31:0]) * 48'(r_gain);
                r_gh <= 31'(r_p[46:32]) * 31'(r_gain);
            end
            mtsw_pkg::OP_W_SUM: begin
                r_quo <= {2'b00, wc};
            end
            mtsw_pkg::OP_DIV5: begin
                r_quo <= {4'd0, div5[61:34]};
            end
            mtsw_pkg::OP_CLICKS: begin
                r_out.horizontal_button <= cx.fire ? (cx.pos ? mtsw_pkg::BTN_RIGHT
                                                            : mtsw_pkg::BTN_LEFT)
                                                   : mtsw_pkg::BTN_NONE;
                r_out.horizontal_clicks <= cx.n;
                r_out.vertical_button   <= cy.fire ? (cy.pos ? mtsw_pkg::BTN_DOWN
                                                            : mtsw_pkg::BTN_UP)
                                                   : mtsw_pkg::BTN_NONE;
                r_out.vertical_clicks   <= cy.n;
            end
            mtsw_pkg::OP_ZERO: begin
                r_out <= '0;
            end
            default: begin
            end
        endcase
    end

    assign o_status.skip = r_skip;
    assign o_out_item    = r_out;

endmodule
`default_nettype wire

// ----- rtl/mtsw_ctrl.sv -----
// controller: sequences the datapath per item and owns the handshakes
`timescale 1ns / 1ps
`default_nettype none
module mtsw_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    input  wire mtsw_pkg::t_status i_status,
    output mtsw_pkg::t_cmd         o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_VINIT = 4'd1;
    localparam logic [3:0] S_VDIV  = 4'd2;
    localparam logic [3:0] S_CINIT = 4'd3;
    localparam logic [3:0] S_CBRT  = 4'd4;
    localparam logic [3:0] S_MULM  = 4'd5;
    localparam logic [3:0] S_MULP  = 4'd6;
    localparam logic [3:0] S_PSUM  = 4'd7;
    localparam logic [3:0] S_MULG  = 4'd8;
    localparam logic [3:0] S_WSUM  = 4'd9;
    localparam logic [3:0] S_MDIV  = 4'd10;
    localparam logic [3:0] S_ACC   = 4'd11;
    localparam logic [3:0] S_DONE  = 4'd12;

    localparam logic [mtsw_pkg::CNT_W-1:0] DIV_LAST  =
        mtsw_pkg::CNT_W'(mtsw_pkg::DIV_STEPS - 1);
    localparam logic [mtsw_pkg::CNT_W-1:0] CBRT_LAST =
        mtsw_pkg::CNT_W'(mtsw_pkg::CBRT_STEPS - 1);

    logic [3:0]                r_state, n_state;
    logic [mtsw_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic                      r_axis, n_axis;
    logic                      r_out_valid, n_out_valid;
    logic [3:0]                op;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_axis      = r_axis;
        n_out_valid = r_out_valid && i_out_stall;
        op          = mtsw_pkg::OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    op      = mtsw_pkg::OP_LOAD;
                    n_axis  = 1'b0;
                    n_state = S_VINIT;
                end
            end
            S_VINIT: begin
                if (i_status.skip) begin
                    n_state = S_DONE;
                end else begin
                    op      = mtsw_pkg::OP_VEL_INIT;
                    n_cnt   = '0;
                    n_state = S_VDIV;
                end
            end
            S_VDIV: begin
                op    = mtsw_pkg::OP_DIV_STEP;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) n_state = S_CINIT;
            end
            S_CINIT: begin
                op      = mtsw_pkg::OP_CBRT_INIT;
                n_cnt   = '0;
                n_state = S_CBRT;
            end
            S_CBRT: begin
                op    = mtsw_pkg::OP_CBRT_STEP;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CBRT_LAST) n_state = S_MULM;
            end
            S_MULM: begin
                op      = mtsw_pkg::OP_MUL_M;
                n_state = S_MULP;
            end
            S_MULP: begin
                op      = mtsw_pkg::OP_MUL_P;
                n_state = S_PSUM;
            end
            S_PSUM: begin
                op      = mtsw_pkg::OP_P_SUM;
                n_state = S_MULG;
            end
            S_MULG: begin
                op      = mtsw_pkg::OP_MUL_G;
                n_state = S_WSUM;
            end
            S_WSUM: begin
                op      = mtsw_pkg::OP_W_SUM;
                n_state = S_MDIV;
            end
            S_MDIV: begin
                op      = mtsw_pkg::OP_DIV5;
                n_state = S_ACC;
            end
            S_ACC: begin
                op = mtsw_pkg::OP_ACC;
                if (!r_axis) begin
                    n_axis  = 1'b1;
                    n_state = S_VINIT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    op          = i_status.skip ? mtsw_pkg::OP_ZERO : mtsw_pkg::OP_CLICKS;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_axis      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_axis      <= n_axis;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd.op    = op;
    assign o_cmd.axis  = r_axis;

endmodule
`default_nettype wire

// ----- rtl/motion_to_scroll_wheel_clicks.sv -----
// top level: pointer motion items in, scroll wheel click items out
// One item is worked on at a time. An item whose time stamp is the first one or
// repeats the last one skips the computation; any other is worked on per axis by
// a restoring divider for the velocity, a cube root unit and nine steps
// (multiplies, saturation, the divide by five as a reciprocal multiply and the
// offset update). A result still stalled at the output holds back the next
// result until it is taken.
// The result waits in an output register while the next item is accepted.
`timescale 1ns / 1ps
`default_nettype none
module motion_to_scroll_wheel_clicks (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire mtsw_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output mtsw_pkg::t_out_item      o_out_item,
    input  wire logic                i_cfg_we,
    input  wire logic                i_cfg_index,
    input  wire logic [15:0]         i_cfg_data
);

    mtsw_pkg::t_cmd    cmd;
    mtsw_pkg::t_status status;

    mtsw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    mtsw_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_status    (status),
        .o_out_item  (o_out_item)
    );

endmodule
`default_nettype wire
